[src/ppc_pkg.sv]
// Shared types, constants and arithmetic helpers of the polar pose controller.
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int POS_WIDTH_DEF     = 32;

    localparam int AW = 19;    // angle arithmetic width, Q3.13 plus headroom for wrapping
    localparam int HW = 16;    // heading and gain field width
    localparam int ZW = 34;    // CORDIC angle accumulator, Q2.30
    localparam int XW = 62;    // CORDIC x/y datapath width
    localparam int QW = 32;    // scale factor quotient width, Q0.32
    localparam int LW = 32;    // limit and speed field width

    localparam logic signed [AW-1:0] PI_Q13     = 19'sd25736;
    localparam logic signed [AW-1:0] TWO_PI_Q13 = 19'sd51472;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [29:0]          INV_GAIN_Q30 = 30'h26DD3B6A;
    localparam logic [QW:0]          SCALE_ONE = {1'b1, {QW{1'b0}}};

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] pose_heading;
    } t_pose;

    typedef struct packed {
        logic signed [31:0] trans_speed;
        logic signed [31:0] rot_speed;
    } t_speed;

    typedef struct packed {
        logic v_neg;
        logic w_neg;
        logic t_act;
        logic r_act;
    } t_div_flags;

    typedef enum logic [2:0] {
        REG_GOAL_X           = 3'd0,
        REG_GOAL_Y           = 3'd1,
        REG_GOAL_HEADING     = 3'd2,
        REG_GAIN_DISTANCE    = 3'd3,
        REG_GAIN_FINAL_ANGLE = 3'd4,
        REG_GAIN_BEARING     = 3'd5,
        REG_TRANS_LIMIT      = 3'd6,
        REG_ROT_LIMIT        = 3'd7
    } t_cfg_reg;

    // arctan(2^-i) in Q2.30, truncated up to index 26, rounded above
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'h3243F6A8;
            5'd1:  r = 32'h1DAC6705;
            5'd2:  r = 32'h0FADBAFC;
            5'd3:  r = 32'h07F56EA6;
            5'd4:  r = 32'h03FEAB76;
            5'd5:  r = 32'h01FFD55B;
            5'd6:  r = 32'h00FFFAAA;
            5'd7:  r = 32'h007FFF55;
            5'd8:  r = 32'h003FFFEA;
            5'd9:  r = 32'h001FFFFD;
            5'd10: r = 32'h000FFFFF;
            5'd11: r = 32'h0007FFFF;
            5'd12: r = 32'h0003FFFF;
            5'd13: r = 32'h0001FFFF;
            5'd14: r = 32'h0000FFFF;
            5'd15: r = 32'h00007FFF;
            5'd16: r = 32'h00003FFF;
            5'd17: r = 32'h00001FFF;
            5'd18: r = 32'h00000FFF;
            5'd19: r = 32'h000007FF;
            5'd20: r = 32'h000003FF;
            5'd21: r = 32'h000001FF;
            5'd22: r = 32'h000000FF;
            5'd23: r = 32'h0000007F;
            5'd24: r = 32'h0000003F;
            5'd25: r = 32'h0000001F;
            5'd26: r = 32'h0000000F;
            5'd27: r = 32'h00000008;
            5'd28: r = 32'h00000004;
            5'd29: r = 32'h00000002;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // wrap into [-pi, pi); handles inputs up to two full turns outside the range
    function automatic logic signed [AW-1:0] wrap_angle(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] r;
        r = a;
        if (r >= PI_Q13) r = r - TWO_PI_Q13;
        if (r >= PI_Q13) r = r - TWO_PI_Q13;
        if (r < -PI_Q13) r = r + TWO_PI_Q13;
        if (r < -PI_Q13) r = r + TWO_PI_Q13;
        return r;
    endfunction

    // sign and magnitude to a saturated 32-bit speed
    function automatic logic signed [LW-1:0] emit_speed(input logic neg, input logic [63:0] mag);
        logic signed [LW-1:0] r;
        if (neg) begin
            r = (mag > 64'h8000_0000) ? 32'sh8000_0000 : -signed'(mag[LW-1:0]);
        end else begin
            r = (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(mag[LW-1:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/ppc_stream_if.sv]
// Valid/ready stream channel carrying one payload type.
`timescale 1ns / 1ps
`default_nettype none

interface ppc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

[src/ppc_cordic_cell.sv]
// One CORDIC vectoring iteration with its own pipeline register.
`timescale 1ns / 1ps
`default_nettype none

module ppc_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_next_en,
    output logic                           o_en,
    input  logic signed [ppc_pkg::XW-1:0]  i_x,
    input  logic signed [ppc_pkg::XW-1:0]  i_y,
    input  logic signed [ppc_pkg::ZW-1:0]  i_z,
    input  logic signed [ppc_pkg::HW-1:0]  i_heading,
    output logic                           o_valid,
    output logic signed [ppc_pkg::XW-1:0]  o_x,
    output logic signed [ppc_pkg::XW-1:0]  o_y,
    output logic signed [ppc_pkg::ZW-1:0]  o_z,
    output logic signed [ppc_pkg::HW-1:0]  o_heading
);
    import ppc_pkg::*;

    localparam logic [4:0] IDX = 5'(SHIFT);

    logic signed [XW-1:0] xs, ys, n_x, n_y;
    logic signed [ZW-1:0] angle, n_z;
    logic                 r_valid;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic signed [HW-1:0] r_heading;

    always_comb begin
        xs    = i_x >>> SHIFT;
        ys    = i_y >>> SHIFT;
        angle = signed'({2'b00, atan_q30(IDX)});
        if (i_y >= 0) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + angle;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - angle;
        end
    end

    assign o_en = !r_valid || i_next_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_x       <= n_x;
            r_y       <= n_y;
            r_z       <= n_z;
            r_heading <= i_heading;
        end
    end

    assign o_valid   = r_valid;
    assign o_x       = r_x;
    assign o_y       = r_y;
    assign o_z       = r_z;
    assign o_heading = r_heading;

endmodule

`default_nettype wire

[src/ppc_div_cell.sv]
// One restoring-division step for the translational and rotational scale factors.
`timescale 1ns / 1ps
`default_nettype none

module ppc_div_cell #(
    parameter int DW = 45
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_next_en,
    output logic                        o_en,
    input  logic [DW-1:0]               i_rem_t,
    input  logic [DW-1:0]               i_den_t,
    input  logic [ppc_pkg::QW-1:0]      i_q_t,
    input  logic [DW-1:0]               i_rem_r,
    input  logic [DW-1:0]               i_den_r,
    input  logic [ppc_pkg::QW-1:0]      i_q_r,
    input  ppc_pkg::t_div_flags         i_flags,
    output logic                        o_valid,
    output logic [DW-1:0]               o_rem_t,
    output logic [DW-1:0]               o_den_t,
    output logic [ppc_pkg::QW-1:0]      o_q_t,
    output logic [DW-1:0]               o_rem_r,
    output logic [DW-1:0]               o_den_r,
    output logic [ppc_pkg::QW-1:0]      o_q_r,
    output ppc_pkg::t_div_flags         o_flags
);
    import ppc_pkg::*;

    logic [DW:0]   sh_t, sh_r, df_t, df_r;
    logic          ge_t, ge_r;
    logic [DW-1:0] n_rem_t, n_rem_r;
    logic [QW-1:0] n_q_t, n_q_r;

    logic          r_valid;
    logic [DW-1:0] r_rem_t, r_den_t, r_rem_r, r_den_r;
    logic [QW-1:0] r_q_t, r_q_r;
    t_div_flags    r_flags;

    // remainder stays below the divisor, so the doubled value needs one extra bit
    always_comb begin
        sh_t    = {i_rem_t, 1'b0};
        sh_r    = {i_rem_r, 1'b0};
        df_t    = sh_t - {1'b0, i_den_t};
        df_r    = sh_r - {1'b0, i_den_r};
        ge_t    = sh_t >= {1'b0, i_den_t};
        ge_r    = sh_r >= {1'b0, i_den_r};
        n_rem_t = ge_t ? df_t[DW-1:0] : sh_t[DW-1:0];
        n_rem_r = ge_r ? df_r[DW-1:0] : sh_r[DW-1:0];
        n_q_t   = {i_q_t[QW-2:0], ge_t};
        n_q_r   = {i_q_r[QW-2:0], ge_r};
    end

    assign o_en = !r_valid || i_next_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_rem_t <= n_rem_t;
            r_den_t <= i_den_t;
            r_q_t   <= n_q_t;
            r_rem_r <= n_rem_r;
            r_den_r <= i_den_r;
            r_q_r   <= n_q_r;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_rem_t = r_rem_t;
    assign o_den_t = r_den_t;
    assign o_q_t   = r_q_t;
    assign o_rem_r = r_rem_r;
    assign o_den_r = r_den_r;
    assign o_q_r   = r_q_r;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

[src/polar_pose_controller_top.sv]
// Polar-coordinate unicycle pose controller: pose in, speed commands out.
//
// i_pose carries one robot pose per transaction (x, y in Q16.16, heading in
// Q3.13); o_speed returns one transaction per pose with translational and
// rotational speed in Q16.16. The goal pose, gains and limits sit in
// registers written through i_cfg_we / i_cfg_index / i_cfg_data; write them
// only while no pose is in flight.
// The datapath is a chain of registered stages: input, pre-rotation, one
// cell per CORDIC iteration, gain correction, angle and gain stages, one
// cell per quotient bit of the two scale-factor dividers (32 cells), then
// factor select, scaling multiply and output register. One pose may enter
// every cycle while the receiver takes every result.
// Each stage advances when it is empty or its successor advances, so a
// stalled receiver holds the output register while earlier bubbles still
// fill and i_pose.ready stays high until the chain is full.
// Synchronous reset empties the pipeline and loads the default registers.
`timescale 1ns / 1ps
`default_nettype none

module polar_pose_controller_top #(
    parameter int CORDIC_STAGES = ppc_pkg::CORDIC_STAGES_DEF,
    parameter int POS_WIDTH     = ppc_pkg::POS_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ppc_stream_if.sink   i_pose,
    ppc_stream_if.source o_speed,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import ppc_pkg::*;

    localparam int GUARD  = 58 - POS_WIDTH;
    localparam int DXW    = POS_WIDTH + 1;
    localparam int RHO_W  = POS_WIDTH + 4;
    // keep at least one bit above the Q0.32 factor width for narrow positions
    localparam int VW     = (RHO_W + 9 > QW + 1) ? (RHO_W + 9) : (QW + 1);
    localparam int HI_W   = VW - QW;
    localparam int NDIV   = QW;

    // configuration registers
    logic signed [31:0]   r_goal_x, r_goal_y, r_trans_limit, r_rot_limit;
    logic signed [HW-1:0] r_goal_heading, r_gain_distance, r_gain_final_angle;
    logic signed [HW-1:0] r_gain_bearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x           <= '0;
            r_goal_y           <= '0;
            r_goal_heading     <= '0;
            r_gain_distance    <= 16'sd768;
            r_gain_final_angle <= -16'sd384;
            r_gain_bearing     <= 16'sd2048;
            r_trans_limit      <= -32'sd65536;
            r_rot_limit        <= -32'sd65536;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_GOAL_X:           r_goal_x           <= i_cfg_data;
                REG_GOAL_Y:           r_goal_y           <= i_cfg_data;
                REG_GOAL_HEADING:     r_goal_heading     <= i_cfg_data[HW-1:0];
                REG_GAIN_DISTANCE:    r_gain_distance    <= i_cfg_data[HW-1:0];
                REG_GAIN_FINAL_ANGLE: r_gain_final_angle <= i_cfg_data[HW-1:0];
                REG_GAIN_BEARING:     r_gain_bearing     <= i_cfg_data[HW-1:0];
                REG_TRANS_LIMIT:      r_trans_limit      <= i_cfg_data;
                REG_ROT_LIMIT:        r_rot_limit        <= i_cfg_data;
                default:              r_goal_x           <= r_goal_x;
            endcase
        end
    end

    // stage enables, computed from the back
    logic en0, en1, en2, en3, en4, en5, en6, en7, en8, en9, en10;

    // ---------------- stage 0: position differences ----------------
    logic signed [POS_WIDTH-1:0] w_px, w_py, w_gx, w_gy;
    logic signed [DXW-1:0]       n0_dx, n0_dy;
    logic                        r0_valid;
    logic signed [DXW-1:0]       r0_dx, r0_dy;
    logic signed [HW-1:0]        r0_heading;

    assign w_px  = POS_WIDTH'(i_pose.data.pose_x);
    assign w_py  = POS_WIDTH'(i_pose.data.pose_y);
    assign w_gx  = POS_WIDTH'(r_goal_x);
    assign w_gy  = POS_WIDTH'(r_goal_y);
    assign n0_dx = {w_gx[POS_WIDTH-1], w_gx} - {w_px[POS_WIDTH-1], w_px};
    assign n0_dy = {w_gy[POS_WIDTH-1], w_gy} - {w_py[POS_WIDTH-1], w_py};

    assign en0          = !r0_valid || en1;
    assign i_pose.ready = en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (en0) begin
            r0_valid <= i_pose.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r0_dx      <= n0_dx;
            r0_dy      <= n0_dy;
            r0_heading <= i_pose.data.pose_heading;
        end
    end

    // ---------------- stage 1: guard bits and pre-rotation ----------------
    logic signed [XW-1:0] s1_x, s1_y, n1_x, n1_y;
    logic signed [ZW-1:0] n1_z;
    logic                 r1_valid;
    logic signed [XW-1:0] r1_x, r1_y;
    logic signed [ZW-1:0] r1_z;
    logic signed [HW-1:0] r1_heading;

    always_comb begin
        s1_x = XW'(r0_dx) <<< GUARD;
        s1_y = XW'(r0_dy) <<< GUARD;
        n1_x = s1_x;
        n1_y = s1_y;
        n1_z = '0;
        // left half plane: rotate by a quarter turn first
        if (s1_x < 0) begin
            if (s1_y >= 0) begin
                n1_x = s1_y;
                n1_y = -s1_x;
                n1_z = HALF_PI_Q30;
            end else begin
                n1_x = -s1_y;
                n1_y = s1_x;
                n1_z = -HALF_PI_Q30;
            end
        end
    end

    logic                 c_valid   [0:CORDIC_STAGES];
    logic                 c_en      [0:CORDIC_STAGES];
    logic signed [XW-1:0] c_x       [0:CORDIC_STAGES];
    logic signed [XW-1:0] c_y       [0:CORDIC_STAGES];
    logic signed [ZW-1:0] c_z       [0:CORDIC_STAGES];
    logic signed [HW-1:0] c_heading [0:CORDIC_STAGES];

    assign en1 = !r1_valid || c_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_x       <= n1_x;
            r1_y       <= n1_y;
            r1_z       <= n1_z;
            r1_heading <= r0_heading;
        end
    end

    assign c_valid[0]   = r1_valid;
    assign c_x[0]       = r1_x;
    assign c_y[0]       = r1_y;
    assign c_z[0]       = r1_z;
    assign c_heading[0] = r1_heading;
    assign c_en[CORDIC_STAGES] = en2;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        ppc_cordic_cell #(.SHIFT(k)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (c_valid[k]),
            .i_next_en (c_en[k+1]),
            .o_en      (c_en[k]),
            .i_x       (c_x[k]),
            .i_y       (c_y[k]),
            .i_z       (c_z[k]),
            .i_heading (c_heading[k]),
            .o_valid   (c_valid[k+1]),
            .o_x       (c_x[k+1]),
            .o_y       (c_y[k+1]),
            .o_z       (c_z[k+1]),
            .o_heading (c_heading[k+1])
        );
    end

    // ---------------- stage 2: CORDIC gain correction products ----------------
    logic [XW-2:0]        w_mag;
    logic [XW-2:0]        n2_phi;
    logic [59:0]          n2_plo;
    logic                 r2_valid;
    logic [XW-2:0]        r2_phi;
    logic [59:0]          r2_plo;
    logic signed [ZW-1:0] r2_z;
    logic signed [HW-1:0] r2_heading;

    assign w_mag  = (c_x[CORDIC_STAGES] < 0) ? '0 : c_x[CORDIC_STAGES][XW-2:0];
    assign n2_phi = w_mag[XW-2:30] * INV_GAIN_Q30;
    assign n2_plo = w_mag[29:0] * INV_GAIN_Q30;
    assign en2    = !r2_valid || en3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= c_valid[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_phi     <= n2_phi;
            r2_plo     <= n2_plo;
            r2_z       <= c_z[CORDIC_STAGES];
            r2_heading <= c_heading[CORDIC_STAGES];
        end
    end

    // ---------------- stage 3: rho and bearing ----------------
    logic [XW-1:0]        w_rsum;
    logic signed [ZW-1:0] w_zr;
    logic [RHO_W-1:0]     n3_rho;
    logic signed [AW-1:0] n3_eps;
    logic                 r3_valid;
    logic [RHO_W-1:0]     r3_rho;
    logic signed [AW-1:0] r3_eps;
    logic signed [HW-1:0] r3_heading;

    assign w_rsum = XW'(r2_phi) + XW'(r2_plo >> 30);
    assign n3_rho = RHO_W'(w_rsum >> GUARD);
    assign w_zr   = r2_z + 34'sd65536;
    assign n3_eps = AW'(w_zr >>> 17);
    assign en3    = !r3_valid || en4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_rho     <= n3_rho;
            r3_eps     <= n3_eps;
            r3_heading <= r2_heading;
        end
    end

    // ---------------- stage 4: gamma ----------------
    logic                 w_zero;
    logic signed [AW-1:0] w_gam_raw, w_gam;
    logic                 r4_valid, r4_zero;
    logic [RHO_W-1:0]     r4_rho;
    logic signed [HW-1:0] r4_gamma, r4_heading;

    // at zero distance the bearing is meaningless: steer onto the goal heading
    assign w_zero    = (r3_rho == '0);
    assign w_gam_raw = w_zero ? (AW'(r_goal_heading) - AW'(r3_heading))
                              : (r3_eps - AW'(r3_heading));
    assign w_gam     = wrap_angle(w_gam_raw);
    assign en4       = !r4_valid || en5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en4) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_zero    <= w_zero;
            r4_rho     <= r3_rho;
            r4_gamma   <= w_gam[HW-1:0];
            r4_heading <= r3_heading;
        end
    end

    // ---------------- stage 5: delta ----------------
    logic signed [AW-1:0] w_del;
    logic                 r5_valid;
    logic [RHO_W-1:0]     r5_rho;
    logic signed [HW-1:0] r5_gamma, r5_delta;

    assign w_del = r4_zero ? '0 : wrap_angle(AW'(r_goal_heading) - AW'(r4_gamma)
                                             - AW'(r4_heading));
    assign en5   = !r5_valid || en6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en5) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_rho   <= r4_rho;
            r5_gamma <= r4_gamma;
            r5_delta <= w_del[HW-1:0];
        end
    end

    // ---------------- stage 6: gain products ----------------
    logic signed [HW:0]      w_kr;
    logic                    w_kneg;
    logic [HW:0]             w_kabs;
    logic                    r6_valid, r6_vneg;
    logic [RHO_W+HW:0]       r6_pv;
    logic signed [2*HW-1:0]  r6_pg, r6_pd;

    assign w_kr   = (HW+1)'(r_gain_distance);
    assign w_kneg = r_gain_distance < 0;
    assign w_kabs = w_kneg ? unsigned'(-w_kr) : unsigned'(w_kr);
    assign en6    = !r6_valid || en7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (en6) begin
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r6_vneg <= w_kneg;
            r6_pv   <= w_kabs * r5_rho;
            r6_pg   <= r_gain_bearing * r5_gamma;
            r6_pd   <= r_gain_final_angle * r5_delta;
        end
    end

    // ---------------- stage 7: speed magnitudes and limit checks ----------------
    logic [VW-1:0]          w_vmag, w_wmag, w_tlim, w_rlim;
    logic signed [2*HW:0]   w_wsum;
    logic signed [2*HW-5:0] w_w;
    logic                   w_wneg, w_tpos, w_rpos;
    t_div_flags             n7_flags;
    logic                   r7_valid;
    logic [VW-1:0]          r7_vmag, r7_wmag, r7_tlim, r7_rlim;
    t_div_flags             r7_flags;

    assign w_vmag = VW'(r6_pv >> 8);
    assign w_wsum = (2*HW+1)'(r6_pg) + (2*HW+1)'(r6_pd);
    assign w_w    = (2*HW-4)'(w_wsum >>> 5);
    assign w_wneg = w_w < 0;
    assign w_wmag = VW'(w_wneg ? unsigned'(-w_w) : unsigned'(w_w));
    assign w_tlim = VW'(r_trans_limit[LW-2:0]);
    assign w_rlim = VW'(r_rot_limit[LW-2:0]);
    assign w_tpos = !r_trans_limit[LW-1] && (r_trans_limit != 0);
    assign w_rpos = !r_rot_limit[LW-1] && (r_rot_limit != 0);

    always_comb begin
        n7_flags.v_neg = r6_vneg;
        n7_flags.w_neg = w_wneg;
        n7_flags.t_act = w_tpos && (w_vmag > w_tlim);
        n7_flags.r_act = w_rpos && (w_wmag > w_rlim);
    end

    logic                d_valid [0:NDIV];
    logic                d_en    [0:NDIV];
    logic [VW-1:0]       d_rem_t [0:NDIV];
    logic [VW-1:0]       d_den_t [0:NDIV];
    logic [QW-1:0]       d_q_t   [0:NDIV];
    logic [VW-1:0]       d_rem_r [0:NDIV];
    logic [VW-1:0]       d_den_r [0:NDIV];
    logic [QW-1:0]       d_q_r   [0:NDIV];
    t_div_flags          d_flags [0:NDIV];

    assign en7 = !r7_valid || d_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (en7) begin
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en7) begin
            r7_vmag  <= w_vmag;
            r7_wmag  <= w_wmag;
            r7_tlim  <= w_tlim;
            r7_rlim  <= w_rlim;
            r7_flags <= n7_flags;
        end
    end

    // the limit is below the divisor whenever the factor is used, so it seeds the remainder
    assign d_valid[0] = r7_valid;
    assign d_rem_t[0] = r7_tlim;
    assign d_den_t[0] = r7_vmag;
    assign d_q_t[0]   = '0;
    assign d_rem_r[0] = r7_rlim;
    assign d_den_r[0] = r7_wmag;
    assign d_q_r[0]   = '0;
    assign d_flags[0] = r7_flags;
    assign d_en[NDIV] = en8;

    for (genvar k = 0; k < NDIV; k++) begin : g_div
        ppc_div_cell #(.DW(VW)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (d_valid[k]),
            .i_next_en (d_en[k+1]),
            .o_en      (d_en[k]),
            .i_rem_t   (d_rem_t[k]),
            .i_den_t   (d_den_t[k]),
            .i_q_t     (d_q_t[k]),
            .i_rem_r   (d_rem_r[k]),
            .i_den_r   (d_den_r[k]),
            .i_q_r     (d_q_r[k]),
            .i_flags   (d_flags[k]),
            .o_valid   (d_valid[k+1]),
            .o_rem_t   (d_rem_t[k+1]),
            .o_den_t   (d_den_t[k+1]),
            .o_q_t     (d_q_t[k+1]),
            .o_rem_r   (d_rem_r[k+1]),
            .o_den_r   (d_den_r[k+1]),
            .o_q_r     (d_q_r[k+1]),
            .o_flags   (d_flags[k+1])
        );
    end

    // ---------------- stage 8: pick the smaller factor ----------------
    logic [QW:0]   w_st, w_sr;
    logic          r8_valid, r8_vneg, r8_wneg;
    logic [QW:0]   r8_sat;
    logic [VW-1:0] r8_vmag, r8_wmag;

    assign w_st = d_flags[NDIV].t_act ? {1'b0, d_q_t[NDIV]} : SCALE_ONE;
    assign w_sr = d_flags[NDIV].r_act ? {1'b0, d_q_r[NDIV]} : SCALE_ONE;
    assign en8  = !r8_valid || en9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
        end else if (en8) begin
            r8_valid <= d_valid[NDIV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en8) begin
            r8_sat  <= (w_sr < w_st) ? w_sr : w_st;
            r8_vmag <= d_den_t[NDIV];
            r8_wmag <= d_den_r[NDIV];
            r8_vneg <= d_flags[NDIV].v_neg;
            r8_wneg <= d_flags[NDIV].w_neg;
        end
    end

    // ---------------- stage 9: scaling products ----------------
    logic                r9_valid, r9_vneg, r9_wneg;
    logic [HI_W+QW:0]    r9_vhi, r9_whi;
    logic [2*QW:0]       r9_vlo, r9_wlo;

    assign en9 = !r9_valid || en10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_valid <= 1'b0;
        end else if (en9) begin
            r9_valid <= r8_valid;
        end
    end

    // a factor of one reproduces the magnitude exactly, so always multiply
    always_ff @(posedge i_clk) begin
        if (en9) begin
            r9_vhi  <= r8_vmag[VW-1:QW] * r8_sat;
            r9_vlo  <= r8_vmag[QW-1:0] * r8_sat;
            r9_whi  <= r8_wmag[VW-1:QW] * r8_sat;
            r9_wlo  <= r8_wmag[QW-1:0] * r8_sat;
            r9_vneg <= r8_vneg;
            r9_wneg <= r8_wneg;
        end
    end

    // ---------------- stage 10: output register ----------------
    logic [HI_W+QW+1:0] w_vfin, w_wfin;
    logic               r10_valid;
    t_speed             r10_speed;

    assign w_vfin = (HI_W+QW+2)'(r9_vhi) + (HI_W+QW+2)'(r9_vlo >> QW);
    assign w_wfin = (HI_W+QW+2)'(r9_whi) + (HI_W+QW+2)'(r9_wlo >> QW);
    assign en10   = !r10_valid || o_speed.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_valid <= 1'b0;
        end else if (en10) begin
            r10_valid <= r9_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en10) begin
            r10_speed.trans_speed <= emit_speed(r9_vneg, 64'(w_vfin));
            r10_speed.rot_speed   <= emit_speed(r9_wneg, 64'(w_wfin));
        end
    end

    assign o_speed.valid = r10_valid;
    assign o_speed.data  = r10_speed;

endmodule

`default_nettype wire

[src/ppc_checker.sv]
// Port-level checks of the pose controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ppc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    // a pending result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output transaction dropped while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // an empty output stage lets the whole chain advance
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output stage");

    // a taken result frees every stage behind it
    a_ready_when_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while receiver is ready");

endmodule

bind polar_pose_controller_top ppc_checker u_ppc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pose.ready),
    .i_out_valid (o_speed.valid),
    .i_out_ready (o_speed.ready)
);

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the polar pose controller with random stalls and register phases.
`timescale 1ns / 1ps

module tb;
    import ppc_pkg::*;

    localparam int  LATENCY   = 59;
    localparam int  DRAIN     = LATENCY + 20;
    localparam int  IDLE_MAX  = 4000;
    localparam int  HOLD_LEN  = 250;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    ppc_stream_if #(.T(t_pose))  pose_ch();
    ppc_stream_if #(.T(t_speed)) speed_ch();

    polar_pose_controller_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pose      (pose_ch.sink),
        .o_speed     (speed_ch.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // shadow copy of the controller registers
    logic signed [31:0] goal_x = 0, goal_y = 0, trans_lim = -65536, rot_lim = -65536;
    logic signed [15:0] goal_hdg = 0, kr = 768, kd = -384, kg = 2048;

    t_pose  pose_queue[$];
    t_speed speed_expected[$];
    int     fail_count = 0;
    int     poses_accepted = 0;
    int     idle_cycles = 0;

    longint atan_tbl[16] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

    function automatic longint wrap_q13(longint a);
        while (a >= 25736) a -= 51472;
        while (a < -25736) a += 51472;
        return a;
    endfunction

    function automatic longint unsigned factor_for(longint lim, longint unsigned m);
        if (lim > 0 && m > longint'(lim))
            return (longint'(lim) << 32) / m;
        return 64'd1 << 32;
    endfunction

    function automatic longint unsigned apply_factor(longint unsigned m, longint unsigned s);
        return (m >> 32) * s + (((m & 64'hFFFF_FFFF) * s) >> 32);
    endfunction

    function automatic logic signed [31:0] clamp_speed(bit neg, longint unsigned m);
        if (neg) return (m > 64'h8000_0000) ? 32'sh8000_0000 : -m[31:0];
        return (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : m[31:0];
    endfunction

    function automatic t_speed predict_speed(t_pose p);
        longint x, y, z, t, xs, ys, eps, gam, del, w, ph;
        longint unsigned mag, rho, vmag, wmag, st, sr, s;
        bit vneg, wneg;
        t_speed r;
        x = (longint'(goal_x) - longint'(p.pose_x)) * 64'sd67108864;
        y = (longint'(goal_y) - longint'(p.pose_y)) * 64'sd67108864;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = 1686629713;
            end else begin
                x = -y; y = t; z = -1686629713;
            end
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_tbl[i];
            end else begin
                x -= ys; y += xs; z -= atan_tbl[i];
            end
        end
        mag = (x < 0) ? 0 : x;
        rho = ((mag >> 30) * 64'h26DD3B6A + (((mag & 64'h3FFF_FFFF) * 64'h26DD3B6A) >> 30)) >> 26;
        eps = (z + 65536) >>> 17;
        ph = longint'(p.pose_heading);
        if (rho == 0) begin
            gam = wrap_q13(longint'(goal_hdg) - ph);
            del = 0;
        end else begin
            gam = wrap_q13(eps - ph);
            del = wrap_q13(longint'(goal_hdg) - gam - ph);
        end
        vneg = kr < 0;
        vmag = ((vneg ? -longint'(kr) : longint'(kr)) * rho) >> 8;
        w = (longint'(kg) * gam + longint'(kd) * del) >>> 5;
        wneg = w < 0;
        wmag = wneg ? -w : w;
        st = factor_for(longint'(trans_lim), vmag);
        sr = factor_for(longint'(rot_lim), wmag);
        s = (sr < st) ? sr : st;
        if (s < (64'd1 << 32)) begin
            vmag = apply_factor(vmag, s);
            wmag = apply_factor(wmag, s);
        end
        r.trans_speed = clamp_speed(vneg, vmag);
        r.rot_speed   = clamp_speed(wneg, wmag);
        return r;
    endfunction

    // pose driver: bursts of random length, random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pose_ch.valid <= 1'b0;
            pose_ch.data  <= '0;
        end else if (!pose_ch.valid || pose_ch.ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                pose_ch.valid <= 1'b0;
            end else if (pose_queue.size() > 0) begin
                pose_ch.data  <= pose_queue.pop_front();
                pose_ch.valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                pose_ch.valid <= 1'b0;
            end
        end
    end

    // speed receiver: stall pattern redrawn at random in phases, one long hold-off
    int stall_mode = 0;
    int mode_cycles = 0;
    int hold_left = 0;
    bit hold_done = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            speed_ch.ready <= 1'b0;
        end else begin
            mode_cycles <= mode_cycles + 1;
            if (mode_cycles % 64 == 63) stall_mode <= $urandom_range(0, 2);
            // start the hold early in a long phase so the sender keeps offering
            if (!hold_done && poses_accepted >= 150) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_LEN;
                speed_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                speed_ch.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: speed_ch.ready <= 1'b1;
                    1: speed_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: speed_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // predict on input transactions, check output transactions, watch for hangs
    always @(posedge i_clk) begin
        t_speed exp_s;
        if (i_rst_n) begin
            if (pose_ch.valid && pose_ch.ready) begin
                speed_expected.push_back(predict_speed(pose_ch.data));
                poses_accepted <= poses_accepted + 1;
            end
            if (speed_ch.valid && speed_ch.ready) begin
                if (speed_expected.size() == 0) begin
                    $display("%0t: unexpected speed transaction %h", $realtime, speed_ch.data);
                    fail_count = fail_count + 1;
                end else begin
                    exp_s = speed_expected.pop_front();
                    if (exp_s.trans_speed !== speed_ch.data.trans_speed) begin
                        $display("%0t: trans_speed expected %0d actual %0d", $realtime,
                                 exp_s.trans_speed, speed_ch.data.trans_speed);
                        fail_count = fail_count + 1;
                    end
                    if (exp_s.rot_speed !== speed_ch.data.rot_speed) begin
                        $display("%0t: rot_speed expected %0d actual %0d", $realtime,
                                 exp_s.rot_speed, speed_ch.data.rot_speed);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if ((pose_ch.valid && pose_ch.ready) || (speed_ch.valid && speed_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_MAX) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(t_cfg_reg r, logic [31:0] v);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        case (r)
            REG_GOAL_X:           goal_x = v;
            REG_GOAL_Y:           goal_y = v;
            REG_GOAL_HEADING:     goal_hdg = v[15:0];
            REG_GAIN_DISTANCE:    kr = v[15:0];
            REG_GAIN_FINAL_ANGLE: kd = v[15:0];
            REG_GAIN_BEARING:     kg = v[15:0];
            REG_TRANS_LIMIT:      trans_lim = v;
            default:              rot_lim = v;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pose_queue.size() > 0 || pose_ch.valid || speed_expected.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic t_pose make_pose(logic [31:0] x, logic [31:0] y, logic [15:0] h);
        t_pose p;
        p.pose_x = x;
        p.pose_y = y;
        p.pose_heading = h;
        return p;
    endfunction

    function automatic logic [15:0] rand_heading();
        case ($urandom_range(0, 5))
            0: return 16'($urandom());
            1: return 16'(25736);
            2: return -16'(25736);
            default: return 16'($signed($urandom_range(0, 51472)) - 25736);
        endcase
    endfunction

    // mostly poses near the goal so rho stays small, plus full-range noise
    task automatic queue_random(int n);
        logic [31:0] x, y;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 4))
                0: begin x = $urandom(); y = $urandom(); end
                1: begin
                    x = goal_x + 32'($signed($urandom_range(0, 8)) - 4);
                    y = goal_y + 32'($signed($urandom_range(0, 8)) - 4);
                end
                default: begin
                    x = goal_x + 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
                    y = goal_y + 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
                end
            endcase
            pose_queue.push_back(make_pose(x, y, rand_heading()));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: limits disabled
        pose_queue.push_back(make_pose(32'h0, 32'h0, 16'h0));
        pose_queue.push_back(make_pose(32'h0, 32'h0, 16'(25736)));
        pose_queue.push_back(make_pose(32'h0, 32'h0, -16'(25736)));
        pose_queue.push_back(make_pose(32'h0, 32'h0, 16'h8000));
        pose_queue.push_back(make_pose(32'h0, 32'h0, 16'h7FFF));
        pose_queue.push_back(make_pose(32'h8000_0000, 32'h8000_0000, 16'h0));
        pose_queue.push_back(make_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF));
        pose_queue.push_back(make_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'h1000));
        pose_queue.push_back(make_pose(32'h7FFF_FFFF, 32'h0, 16'h0));
        pose_queue.push_back(make_pose(32'hFFFF_FFFF, 32'h0, 16'h0));
        pose_queue.push_back(make_pose(32'h0, 32'hFFFF_0000, 16'h0));
        pose_queue.push_back(make_pose(32'h0001_0000, 32'h0, 16'h0));
        pose_queue.push_back(make_pose(32'h0, 32'h0000_0001, 16'h0));
        wait_idle();

        // goal at the far corner, extreme gains, tight limits
        write_reg(REG_GOAL_X, 32'h7FFF_FFFF);
        write_reg(REG_GOAL_Y, 32'h8000_0000);
        write_reg(REG_GOAL_HEADING, 32'(-25736));
        write_reg(REG_GAIN_DISTANCE, 32'h0000_7FFF);
        write_reg(REG_GAIN_FINAL_ANGLE, 32'hFFFF_8000);
        write_reg(REG_GAIN_BEARING, 32'h0000_7FFF);
        write_reg(REG_TRANS_LIMIT, 32'h0001_0000);
        write_reg(REG_ROT_LIMIT, 32'h0000_8000);
        pose_queue.push_back(make_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'h0));
        pose_queue.push_back(make_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'(25736)));
        pose_queue.push_back(make_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000));
        pose_queue.push_back(make_pose(32'h0, 32'h0, 16'h7FFF));
        pose_queue.push_back(make_pose(32'h7FFF_0000, 32'h8001_0000, 16'h0));
        queue_random(120);
        wait_idle();

        // negative distance gain, one limit zero, the other at maximum
        write_reg(REG_GOAL_X, 32'h0003_0000);
        write_reg(REG_GOAL_Y, 32'hFFFE_8000);
        write_reg(REG_GOAL_HEADING, 32'(25736));
        write_reg(REG_GAIN_DISTANCE, 32'hFFFF_8000);
        write_reg(REG_GAIN_FINAL_ANGLE, 32'h0000_7FFF);
        write_reg(REG_GAIN_BEARING, 32'hFFFF_8000);
        write_reg(REG_TRANS_LIMIT, 32'h0);
        write_reg(REG_ROT_LIMIT, 32'h7FFF_FFFF);
        queue_random(150);
        wait_idle();

        // random settings, small limits so scaling kicks in often
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(REG_GOAL_X, $urandom());
            write_reg(REG_GOAL_Y, $urandom());
            write_reg(REG_GOAL_HEADING, 32'($signed($urandom_range(0, 51472)) - 25736));
            write_reg(REG_GAIN_DISTANCE, {{16{1'b0}}, 16'($urandom())});
            write_reg(REG_GAIN_FINAL_ANGLE, 32'($signed(16'($urandom()))));
            write_reg(REG_GAIN_BEARING, 32'($signed(16'($urandom()))));
            write_reg(REG_TRANS_LIMIT, ($urandom_range(0, 3) == 0) ? $urandom()
                                                                   : $urandom_range(1, 1 << 20));
            write_reg(REG_ROT_LIMIT, ($urandom_range(0, 3) == 0) ? $urandom()
                                                                 : $urandom_range(1, 1 << 20));
            queue_random(95);
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
